FILE: hw/rtl/ats_eligibility_time_meter_core_macros.svh
// Assertion macros for the eligibility time meter.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
// The synthesis build gets empty bodies.
`ifndef ATS_ELIGIBILITY_TIME_METER_CORE_MACROS_SVH
`define ATS_ELIGIBILITY_TIME_METER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Concurrent assertion on a named clock and active-low reset.
`define ATS_ETM_ASSERT_CLK(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define ATS_ETM_ASSERT(lbl, prop, msg) \
  `ATS_ETM_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`else

`define ATS_ETM_ASSERT_CLK(lbl, clk_sig, rst_sig, prop, msg)

`define ATS_ETM_ASSERT(lbl, prop, msg)

`endif

`endif

FILE: hw/rtl/ats_etm_pkg.sv
// Shared types and constants of the eligibility time meter.
// No dependencies; every RTL module imports this package.
package ats_etm_pkg;

  // Defaults of the top-level parameters.
  localparam int NUM_PORTS_DEF = 8;
  localparam int NUM_PRIO_DEF  = 8;
  localparam int TIME_BITS_DEF = 48;

  // Depth of the request queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Field widths.
  localparam int RATE_W  = 37;
  localparam int BURST_W = 24;
  localparam int OVH_W   = 10;
  localparam int RES_W   = 48;
  localparam int ARR_W   = 48;
  localparam int LEN_W   = 17;
  localparam int PORT_W  = 3;
  localparam int PCP_W   = 3;
  localparam int ELIG_W  = 48;

  // Configuration port.
  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;

  // Nanoseconds per second and the width of a scaled bit count.
  localparam int             NS_W     = 30;
  localparam logic [NS_W-1:0] NS_PER_S = 30'd1000000000;
  localparam int             QUOT_W   = BURST_W + NS_W;

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COMMITTED_RATE  = 3'd0,
    CFG_COMMITTED_BURST = 3'd1,
    CFG_OVERHEAD        = 3'd2,
    CFG_RES_CHECK_EN    = 3'd3,
    CFG_MAX_RESIDENCE   = 3'd4
  } ats_etm_cfg_idx_t;

  // One frame request.
  typedef struct packed {
    logic [ARR_W-1:0] arrival_time_ns;
    logic [LEN_W-1:0] frame_length_bits;
    logic [PORT_W-1:0] port_index;
    logic [PCP_W-1:0] priority_code;
  } ats_etm_in_t;

  // One result.
  typedef struct packed {
    logic [ELIG_W-1:0] eligibility_time_ns;
    logic              accepted;
  } ats_etm_out_t;

  // Configuration register set.
  typedef struct packed {
    logic [RATE_W-1:0]  committed_rate_bps;
    logic [BURST_W-1:0] committed_burst_bits;
    logic [OVH_W-1:0]   overhead_bits;
    logic               residence_check_enable;
    logic [RES_W-1:0]   max_residence_ns;
  } ats_etm_cfg_t;

  // Queue head status, front to back.
  typedef struct packed {
    logic valid;
    logic group_ok;
  } ats_etm_q_t;

  // Back status, back to front.
  typedef struct packed {
    logic pop;
    logic clearing;
  } ats_etm_bk_t;

endpackage

FILE: hw/rtl/ats_etm_front.sv
// Front end of the meter: takes requests, classifies the group and queues them.
// Depends on ats_etm_pkg.
module ats_etm_front #(
  parameter int NUM_PORTS      = ats_etm_pkg::NUM_PORTS_DEF,
  parameter int NUM_PRIORITIES = ats_etm_pkg::NUM_PRIO_DEF,
  parameter int GIDX_W         = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  ats_etm_pkg::ats_etm_in_t in_data,
  input  ats_etm_pkg::ats_etm_bk_t bk_status,
  output ats_etm_pkg::ats_etm_q_t  q_head,
  output ats_etm_pkg::ats_etm_in_t q_item,
  output logic [GIDX_W-1:0]        q_gidx
);
  import ats_etm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    ats_etm_in_t       item;
    logic              gok;
    logic [GIDX_W-1:0] gidx;
  } ent_t;

  ent_t              q_mem [QUEUE_DEPTH];
  ent_t              ent_in;
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              push;
  logic              pop;
  logic [31:0]       gidx_full;

  // Group classification: out-of-range port or priority has no table entry.
  always_comb begin
    gidx_full = 32'(in_data.port_index) * 32'(NUM_PRIORITIES)
              + 32'(in_data.priority_code);
    ent_in.item = in_data;
    ent_in.gok  = (32'(in_data.port_index) < 32'(NUM_PORTS)) &&
                  (32'(in_data.priority_code) < 32'(NUM_PRIORITIES));
    ent_in.gidx = ent_in.gok ? GIDX_W'(gidx_full) : '0;
  end

  // Accept while the queue has room and the group table is not being cleared.
  assign busy = (cnt_r == CNT_W'(QUEUE_DEPTH)) || bk_status.clearing;
  assign push = start && !busy;
  assign pop  = bk_status.pop;

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= ent_in;
    end
  end

  // Head of the queue.
  assign q_head.valid    = (cnt_r != '0);
  assign q_head.group_ok = q_mem[rd_ptr_r].gok;
  assign q_item          = q_mem[rd_ptr_r].item;
  assign q_gidx          = q_mem[rd_ptr_r].gidx;

endmodule

FILE: hw/rtl/ats_etm_div.sv
// Radix-2 restoring divider lane, one quotient bit per cycle.
// Depends on ats_etm_pkg.
module ats_etm_div #(
  parameter int NUM_W = ats_etm_pkg::QUOT_W,
  parameter int DEN_W = ats_etm_pkg::RATE_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic [NUM_W-1:0] quot,
  output logic             done
);
  import ats_etm_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [NUM_W-1:0] quo_nxt;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_sh;
  logic             fits;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  // One trial subtraction: shift in the next numerator bit.
  always_comb begin
    rem_sh  = {rem_r, quo_r[NUM_W-1]};
    fits    = (rem_sh >= {1'b0, den_r});
    rem_nxt = fits ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
    quo_nxt = {quo_r[NUM_W-2:0], fits};
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (load) begin
        cnt_r <= CNT_W'(NUM_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (load) begin
      quo_r <= numer;
      rem_r <= '0;
      den_r <= denom;
    end else if (cnt_r != '0) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quot = quo_r;
  assign done = done_r;

endmodule

FILE: hw/rtl/ats_etm_back.sv
// Back end of the meter: divides, computes the eligibility time, updates state.
// Depends on ats_etm_pkg, ats_etm_div and the assertion macro header.
`include "ats_eligibility_time_meter_core_macros.svh"

module ats_etm_back #(
  parameter int NUM_PORTS      = ats_etm_pkg::NUM_PORTS_DEF,
  parameter int NUM_PRIORITIES = ats_etm_pkg::NUM_PRIO_DEF,
  parameter int TIME_BITS      = ats_etm_pkg::TIME_BITS_DEF,
  parameter int GIDX_W         = 6
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ats_etm_pkg::ats_etm_cfg_t cfg,
  input  ats_etm_pkg::ats_etm_q_t   q_head,
  input  ats_etm_pkg::ats_etm_in_t  q_item,
  input  logic [GIDX_W-1:0]         q_gidx,
  output ats_etm_pkg::ats_etm_bk_t  bk_status,
  output logic                      out_valid,
  output ats_etm_pkg::ats_etm_out_t out_data
);
  import ats_etm_pkg::*;

  localparam int NUM_GROUPS = NUM_PORTS * NUM_PRIORITIES;
  localparam int EXT_W      = (TIME_BITS > QUOT_W) ? TIME_BITS : QUOT_W;
  localparam logic [TIME_BITS-1:0] TMAX     = {TIME_BITS{1'b1}};
  localparam logic [EXT_W-1:0]     TMAX_EXT = {EXT_W{1'b1}} >> (EXT_W - TIME_BITS);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_LOAD, S_DIV, S_SUM, S_ELIG, S_CHK, S_DONE
  } state_t;

  // Saturate a wide value to the time range.
  function automatic logic [TIME_BITS-1:0] clamp_t(input logic [EXT_W-1:0] v);
    clamp_t = (v > TMAX_EXT) ? TMAX : v[TIME_BITS-1:0];
  endfunction

  // Saturating time addition.
  function automatic logic [TIME_BITS-1:0] add_sat(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    add_sat = s[TIME_BITS] ? TMAX : s[TIME_BITS-1:0];
  endfunction

  state_t                 state_r;
  logic [GIDX_W-1:0]      clr_cnt_r;
  logic [TIME_BITS-1:0]   bucket_r;
  logic                   out_valid_r;
  ats_etm_out_t           out_data_r;

  logic [TIME_BITS-1:0]   arr_r;
  logic [LEN_W-1:0]       len_r;
  logic                   gok_r;
  logic [GIDX_W-1:0]      gidx_r;
  logic [TIME_BITS-1:0]   rec_r;
  logic [TIME_BITS-1:0]   fill_r;
  logic [TIME_BITS-1:0]   sched_r;
  logic [TIME_BITS-1:0]   full_r;
  logic [TIME_BITS-1:0]   limit_r;
  logic [TIME_BITS-1:0]   grp_time_r;
  logic [TIME_BITS-1:0]   elig_r;
  logic                   ok_r;
  logic                   lt_full_r;
  logic [TIME_BITS-1:0]   over_r;

  logic [TIME_BITS-1:0]   grp_mem [NUM_GROUPS];
  logic [TIME_BITS-1:0]   grp_rd_r;
  logic                   mem_we;
  logic [GIDX_W-1:0]      mem_waddr;
  logic [TIME_BITS-1:0]   mem_wdata;

  logic                   div_load;
  logic [1:0]             div_done;
  logic [QUOT_W-1:0]      num_rec;
  logic [QUOT_W-1:0]      num_fill;
  logic [QUOT_W-1:0]      quot_rec;
  logic [QUOT_W-1:0]      quot_fill;
  logic [LEN_W:0]         rec_bits;
  logic                   rate_zero;
  logic [TIME_BITS-1:0]   elig_mid;
  logic [TIME_BITS-1:0]   elig_max;
  logic [EXT_W-1:0]       elig_ext;

  // Status toward the front end.
  assign bk_status.pop      = (state_r == S_IDLE) && q_head.valid;
  assign bk_status.clearing = (state_r == S_CLR);

  // Scaled bit counts; the lanes register them at load.
  assign rec_bits  = (LEN_W + 1)'(len_r) + (LEN_W + 1)'(cfg.overhead_bits);
  assign num_rec   = QUOT_W'(rec_bits) * QUOT_W'(NS_PER_S);
  assign num_fill  = QUOT_W'(cfg.committed_burst_bits) * QUOT_W'(NS_PER_S);
  assign div_load  = (state_r == S_LOAD);
  assign rate_zero = (cfg.committed_rate_bps == '0);

  // Length recovery time lane.
  ats_etm_div #(.NUM_W(QUOT_W), .DEN_W(RATE_W)) u_div_rec (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (div_load),
    .numer (num_rec),
    .denom (cfg.committed_rate_bps),
    .quot  (quot_rec),
    .done  (div_done[0])
  );

  // Burst fill time lane.
  ats_etm_div #(.NUM_W(QUOT_W), .DEN_W(RATE_W)) u_div_fill (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (div_load),
    .numer (num_fill),
    .denom (cfg.committed_rate_bps),
    .quot  (quot_fill),
    .done  (div_done[1])
  );

  // Largest of arrival, group time and scheduler time.
  always_comb begin
    elig_mid = (grp_time_r > arr_r) ? grp_time_r : arr_r;
    elig_max = (sched_r > elig_mid) ? sched_r : elig_mid;
    elig_ext = EXT_W'(elig_r);
  end

  // Group table write port: clearing pass or accepted frame.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = gidx_r;
    mem_wdata = elig_r;
    if (state_r == S_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if ((state_r == S_DONE) && ok_r && gok_r) begin
      mem_we = 1'b1;
    end
  end

  // Group table storage with registered read at the queue head.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      grp_mem[mem_waddr] <= mem_wdata;
    end
    if (bk_status.pop) begin
      grp_rd_r <= grp_mem[q_gidx];
    end
  end

  // Sequencer, bucket state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      bucket_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          if (clr_cnt_r == GIDX_W'(NUM_GROUPS - 1)) begin
            state_r <= S_IDLE;
          end else begin
            clr_cnt_r <= clr_cnt_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (q_head.valid) begin
            arr_r   <= clamp_t(EXT_W'(q_item.arrival_time_ns));
            len_r   <= q_item.frame_length_bits;
            gok_r   <= q_head.group_ok;
            gidx_r  <= q_gidx;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done[0]) begin
            rec_r   <= rate_zero ? TMAX : clamp_t(EXT_W'(quot_rec));
            fill_r  <= rate_zero ? TMAX : clamp_t(EXT_W'(quot_fill));
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          sched_r    <= add_sat(bucket_r, rec_r);
          full_r     <= add_sat(bucket_r, fill_r);
          limit_r    <= add_sat(arr_r, clamp_t(EXT_W'(cfg.max_residence_ns)));
          grp_time_r <= gok_r ? grp_rd_r : '0;
          state_r    <= S_ELIG;
        end
        S_ELIG: begin
          elig_r  <= elig_max;
          state_r <= S_CHK;
        end
        S_CHK: begin
          ok_r      <= !(cfg.residence_check_enable && (elig_r > limit_r));
          lt_full_r <= (elig_r < full_r);
          over_r    <= elig_r - full_r;
          state_r   <= S_DONE;
        end
        S_DONE: begin
          if (ok_r) begin
            bucket_r <= lt_full_r ? sched_r : add_sat(sched_r, over_r);
          end
          out_valid_r                    <= 1'b1;
          out_data_r.eligibility_time_ns <= elig_ext[ELIG_W-1:0];
          out_data_r.accepted            <= ok_r;
          state_r                        <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The two lanes start together and run the same number of steps.
  `ATS_ETM_ASSERT(a_lanes_in_step, div_done[0] == div_done[1], "divider lanes out of step")
  // A result strobe lasts one cycle.
  `ATS_ETM_ASSERT(a_strobe_single, out_valid_r |=> !out_valid_r, "result strobe held")
  // The bucket moves only when an accepted frame completes.
  `ATS_ETM_ASSERT(a_bucket_on_accept, $past(rst_n) && !$stable(bucket_r) |-> $past(state_r == S_DONE && ok_r), "bucket changed outside an accepted frame")

endmodule

FILE: hw/rtl/ats_eligibility_time_meter_core.sv
// Top level of the asynchronous traffic shaper eligibility time meter.
// Depends on ats_etm_pkg, ats_etm_front and ats_etm_back.
//
// Channel   Ports                          Transfer
// input     start, busy, in_data           start high and busy low at a clock edge
// result    out_valid, out_data            one-cycle strobe, always taken
// config    cfg_we, cfg_index, cfg_wdata   cfg_we high at a clock edge
//
// A frame goes from the head of the request queue through the load, divide, sum,
// eligibility, check and done states; the divide state runs the 54-step radix-2
// divider by the committed rate. Two requests can wait in the queue while a frame
// is in the back end. After reset the group table is cleared, one entry per group,
// with busy high until the pass ends; configuration writes are taken at once.
// The receiver cannot stall: each result is on the ports for one cycle.
module ats_eligibility_time_meter_core #(
  parameter int NUM_PORTS      = ats_etm_pkg::NUM_PORTS_DEF,
  parameter int NUM_PRIORITIES = ats_etm_pkg::NUM_PRIO_DEF,
  parameter int TIME_BITS      = ats_etm_pkg::TIME_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  ats_etm_pkg::ats_etm_in_t               in_data,
  output logic                                   out_valid,
  output ats_etm_pkg::ats_etm_out_t              out_data,
  input  logic                                   cfg_we,
  input  logic [ats_etm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ats_etm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import ats_etm_pkg::*;

  localparam int NUM_GROUPS = NUM_PORTS * NUM_PRIORITIES;
  localparam int GIDX_W     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  ats_etm_cfg_t      cfg_r;
  ats_etm_q_t        q_head;
  ats_etm_in_t       q_item;
  logic [GIDX_W-1:0] q_gidx;
  ats_etm_bk_t       bk_status;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.committed_rate_bps     <= 37'd1000000000;
      cfg_r.committed_burst_bits   <= 24'd12000;
      cfg_r.overhead_bits          <= '0;
      cfg_r.residence_check_enable <= 1'b0;
      cfg_r.max_residence_ns       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COMMITTED_RATE:  cfg_r.committed_rate_bps     <= cfg_wdata[RATE_W-1:0];
        CFG_COMMITTED_BURST: cfg_r.committed_burst_bits   <= cfg_wdata[BURST_W-1:0];
        CFG_OVERHEAD:        cfg_r.overhead_bits          <= cfg_wdata[OVH_W-1:0];
        CFG_RES_CHECK_EN:    cfg_r.residence_check_enable <= cfg_wdata[0];
        CFG_MAX_RESIDENCE:   cfg_r.max_residence_ns       <= cfg_wdata[RES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Request intake and queue.
  ats_etm_front #(
    .NUM_PORTS      (NUM_PORTS),
    .NUM_PRIORITIES (NUM_PRIORITIES),
    .GIDX_W         (GIDX_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .bk_status (bk_status),
    .q_head    (q_head),
    .q_item    (q_item),
    .q_gidx    (q_gidx)
  );

  // Division, eligibility computation and state update.
  ats_etm_back #(
    .NUM_PORTS      (NUM_PORTS),
    .NUM_PRIORITIES (NUM_PRIORITIES),
    .TIME_BITS      (TIME_BITS),
    .GIDX_W         (GIDX_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_head    (q_head),
    .q_item    (q_item),
    .q_gidx    (q_gidx),
    .bk_status (bk_status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
